>>> rtl/deq_pkg.sv
// Package for the double-ended queue: default sizes, field widths,
// request/status codes and the cell operation code. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_FRONT = 3'd0,
        FUNC_PUSH_BACK  = 3'd1,
        FUNC_POP_FRONT  = 3'd2,
        FUNC_POP_BACK   = 3'd3,
        FUNC_PEEK_FRONT = 3'd4,
        FUNC_PEEK_BACK  = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_PUSH_FRONT = 3'd1,
        CELL_PUSH_BACK  = 3'd2,
        CELL_POP_FRONT  = 3'd3,
        CELL_POP_BACK   = 3'd4
    } cell_op_t;

endpackage : deq_pkg

`default_nettype wire

>>> rtl/deq_req_if.sv
// Request channel of the double-ended queue: valid/ready plus operation
// code and push word. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if;
    logic                         valid;
    logic                         ready;
    logic [deq_pkg::FUNC_W-1:0]   func;
    logic [deq_pkg::VALUE_W-1:0]  push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface : deq_req_if

`default_nettype wire

>>> rtl/deq_rsp_if.sv
// Response channel of the double-ended queue: valid/ready plus read word,
// status, count and flags. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface deq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [deq_pkg::VALUE_W-1:0]   read_value;
    logic [deq_pkg::STATUS_W-1:0]  status;
    logic [deq_pkg::COUNT_W-1:0]   count;
    logic                          is_empty;
    logic                          is_full;

    modport source (output valid, output read_value, output status, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input read_value, input status, input count,
                    input is_empty, input is_full, output ready);
endinterface : deq_rsp_if

`default_nettype wire

>>> rtl/deq_cell.sv
// One storage cell of the deque chain: a data word and an occupied bit,
// loaded from a neighbor or from the push word. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_cell #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire deq_pkg::cell_op_t     op,
    input  wire logic [DATA_WIDTH-1:0] push_data,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic                  left_occ,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic                  right_occ,
    output logic      [DATA_WIDTH-1:0] data,
    output logic                       occ
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  occ_reg;
    logic                  occ_next;

    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        unique case (op)
            deq_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            deq_pkg::CELL_PUSH_FRONT:
            begin
                data_next = left_data;
                occ_next  = left_occ;
            end
            deq_pkg::CELL_PUSH_BACK:
            begin
                // first free cell takes the word
                if (!occ_reg && left_occ)
                begin
                    data_next = push_data;
                end
                occ_next = left_occ;
            end
            deq_pkg::CELL_POP_FRONT:
            begin
                data_next = right_data;
                occ_next  = right_occ;
            end
            deq_pkg::CELL_POP_BACK:
            begin
                occ_next = right_occ;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign occ  = occ_reg;

endmodule : deq_cell

`default_nettype wire

>>> rtl/double_ended_queue.sv
// Double-ended queue top level: a chain of DEPTH cells with the front at
// cell 0, a fill counter and a registered response stage.
// Latency: a response is valid the cycle after its request is accepted.
// Throughput: one request per cycle while rsp.ready stays high; a waiting response stalls req.
// Reset clears occupancy, the count and the response valid; cell data is
// not reset and is only read once written.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    // widths used to move between port words and the internal sizes
    localparam int VAL_EXT_W = (DATA_WIDTH > deq_pkg::VALUE_W) ? DATA_WIDTH : deq_pkg::VALUE_W;
    localparam int CNT_EXT_W = (CNT_W > deq_pkg::COUNT_W) ? CNT_W : deq_pkg::COUNT_W;

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    deq_pkg::cell_op_t      cell_op;
    logic [DATA_WIDTH-1:0]  push_data;
    logic [VAL_EXT_W-1:0]   push_ext;
    logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
    logic [DEPTH-1:0]       cell_occ;
    logic [DEPTH-1:0]       last_sel;

    // keep the low DATA_WIDTH bits of the push word
    assign push_ext  = VAL_EXT_W'(req.push_value);
    assign push_data = push_ext[DATA_WIDTH-1:0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic                  left_occ;
        logic [DATA_WIDTH-1:0] right_data;
        logic                  right_occ;

        if (i == 0)
        begin : g_first
            // push front enters here; the front is always reachable
            assign left_data = push_data;
            assign left_occ  = 1'b1;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
            assign left_occ  = cell_occ[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[i];
            assign right_occ  = 1'b0;
            assign last_sel[i] = cell_occ[i];
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
            assign right_occ  = cell_occ[i+1];
            // back entry: last occupied cell of the thermometer
            assign last_sel[i] = cell_occ[i] && !cell_occ[i+1];
        end

        deq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (cell_op),
            .push_data  (push_data),
            .left_data  (left_data),
            .left_occ   (left_occ),
            .right_data (right_data),
            .right_occ  (right_occ),
            .data       (cell_data[i]),
            .occ        (cell_occ[i])
        );
    end

    // ---------------------------------------------------------------
    // Read side: front is cell 0, back is a one-hot OR over the chain
    // ---------------------------------------------------------------
    logic [DATA_WIDTH-1:0] back_data;

    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_data = back_data | ({DATA_WIDTH{last_sel[i]}} & cell_data[i]);
        end
    end

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    logic                     fire;
    logic                     now_empty;
    logic                     now_full;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [DATA_WIDTH-1:0]    rd_data;
    deq_pkg::status_t         status_next;

    assign now_empty = !cell_occ[0];
    assign now_full  = cell_occ[DEPTH-1];
    assign fire      = req.valid && req.ready;

    always_comb
    begin
        cell_op     = deq_pkg::CELL_HOLD;
        count_next  = count_reg;
        rd_data     = '0;
        status_next = deq_pkg::STATUS_OK;
        unique case (req.func) inside
            deq_pkg::FUNC_PUSH_FRONT,
            deq_pkg::FUNC_PUSH_BACK:
            begin
                if (now_full)
                begin
                    status_next = deq_pkg::STATUS_FULL;
                end
                else
                begin
                    cell_op    = (req.func == deq_pkg::FUNC_PUSH_FRONT) ?
                                 deq_pkg::CELL_PUSH_FRONT : deq_pkg::CELL_PUSH_BACK;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::FUNC_POP_FRONT,
            deq_pkg::FUNC_PEEK_FRONT:
            begin
                if (now_empty)
                begin
                    status_next = deq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    rd_data = cell_data[0];
                    if (req.func == deq_pkg::FUNC_POP_FRONT)
                    begin
                        cell_op    = deq_pkg::CELL_POP_FRONT;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            deq_pkg::FUNC_POP_BACK,
            deq_pkg::FUNC_PEEK_BACK:
            begin
                if (now_empty)
                begin
                    status_next = deq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    rd_data = back_data;
                    if (req.func == deq_pkg::FUNC_POP_BACK)
                    begin
                        cell_op    = deq_pkg::CELL_POP_BACK;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                // unknown code: no change, report current state
                status_next = deq_pkg::STATUS_OK;
            end
        endcase
        if (!fire)
        begin
            cell_op    = deq_pkg::CELL_HOLD;
            count_next = count_reg;
        end
    end

    // ---------------------------------------------------------------
    // Response register; a new request is taken while the current
    // response is being consumed
    // ---------------------------------------------------------------
    logic                          rsp_valid_reg;
    logic [deq_pkg::VALUE_W-1:0]   read_value_reg;
    deq_pkg::status_t              status_reg;
    logic [deq_pkg::COUNT_W-1:0]   count_out_reg;
    logic                          is_empty_reg;
    logic                          is_full_reg;
    logic [VAL_EXT_W-1:0]          rd_ext;
    logic [CNT_EXT_W-1:0]          cnt_ext;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign rd_ext    = VAL_EXT_W'(rd_data);
    assign cnt_ext   = CNT_EXT_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_value_reg <= rd_ext[deq_pkg::VALUE_W-1:0];
            status_reg     <= status_next;
            count_out_reg  <= cnt_ext[deq_pkg::COUNT_W-1:0];
            is_empty_reg   <= (count_next == '0);
            is_full_reg    <= (count_next == CNT_W'(DEPTH));
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.count      = count_out_reg;
    assign rsp.is_empty   = is_empty_reg;
    assign rsp.is_full    = is_full_reg;

endmodule : double_ended_queue

`default_nettype wire
